// File: design/ssba_pkg.sv
// shared types and constants for the swap slot bitmap allocator
package ssba_pkg;

   localparam int MAX_SLOTS        = 1024;
   localparam int SECTORS_PER_SLOT = 8;

   localparam int SLOT_W    = 10;
   localparam int SECTOR_W  = 13;
   localparam int COUNT_W   = 11;
   localparam int BEAT_W    = $clog2(SECTORS_PER_SLOT);

   localparam int WORD_W     = 32;
   localparam int BIT_SEL_W  = $clog2(WORD_W);
   localparam int MAP_DEPTH  = MAX_SLOTS / WORD_W;
   localparam int MAP_ADDR_W = $clog2(MAP_DEPTH);

   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_SLOTS);
   localparam logic [BEAT_W-1:0]  BEAT_LAST = BEAT_W'(SECTORS_PER_SLOT - 1);

   typedef enum logic [1:0] {
      REQ_ALLOC = 2'd0,
      REQ_READ  = 2'd1,
      REQ_FREE  = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_NOT_USED = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_CHECK,
      S_EMIT,
      S_RESULT
   } state_type;

   // access to the used-bit word store
   typedef struct packed {
      logic                  rd_en;
      logic [MAP_ADDR_W-1:0] rd_addr;
      logic                  wr_en;
      logic [MAP_ADDR_W-1:0] wr_addr;
      logic [WORD_W-1:0]     wr_data;
   } map_req_type;

endpackage

// File: design/swap_slot_bitmap_allocator.sv
// top level of the swap slot bitmap allocator: sequencer, word scan and result register
//
//  channel   dir  ports                     tdata / tuser / tlast
//  req       in   req_tvalid/tready         tdata[9:0] slot_index, tuser[1:0] req_type
//  rsp       out  rsp_tvalid/tready         tdata[9:0] slot_number, tdata[22:10] sector_address
//                                           tuser[0] is_write, tuser[2:1] status, tlast last
//  csr       in   csr_we/csr_wdata          slot_count, 11 bits
//
// allocate: accept, then scan one 32-slot word at a time up to the word with the first
//   free slot (1 to 32), then 8 beats; a full table scans every usable word, then 1 beat
// read back: accept, lookup, 8 beats; free or slot not in use: accept, lookup, 1 beat
// out of range, or allocate with zero slots: accept, then 1 beat with no lookup
// reset clears the bitmap at once through per-word valid flags, no sweep needed
// a stalled rsp holds the sequencer; a new beat is accepted as soon as the last result is staged
module swap_slot_bitmap_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,   // [9:0] slot_index, rest zero
   input  logic [1:0]                      req_tuser,   // [1:0] req_type
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [23:0]                     rsp_tdata,   // [9:0] slot_number, [22:10] sector_address
   output logic [2:0]                      rsp_tuser,   // [0] is_write, [2:1] status
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [ssba_pkg::COUNT_W-1:0]    csr_wdata    // slot_count
);
   import ssba_pkg::*;

   // configuration
   logic [COUNT_W-1:0]    slot_count_ff;
   logic [COUNT_W-1:0]    eff_count;
   logic [COUNT_W-BIT_SEL_W-1:0] count_words;
   logic [BIT_SEL_W-1:0]  count_bits;
   logic [COUNT_W-1:0]    count_less_one;
   logic [MAP_ADDR_W-1:0] last_word;

   // sequencer state
   state_type             state_ff, state_in;
   req_kind_type          kind_ff, kind_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [BEAT_W-1:0]     beat_ff, beat_in;
   status_type            status_ff, status_in;
   logic                  is_write_ff, is_write_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [SECTOR_W-1:0]   rsp_sector_ff, rsp_sector_in;
   logic                  rsp_write_ff, rsp_write_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  out_free;

   // bitmap access
   map_req_type           map_req;
   logic [WORD_W-1:0]     rd_data;
   logic [WORD_W-1:0]     scan_mask;
   logic [WORD_W-1:0]     avail;
   logic [BIT_SEL_W-1:0]  first_free;
   logic [MAP_ADDR_W-1:0] scan_word;

   req_kind_type          in_kind;
   logic [SLOT_W-1:0]     in_slot;
   logic                  in_range;

   ssba_map u_map (
      .clock   (clock),
      .reset   (reset),
      .map_req (map_req),
      .rd_data (rd_data)
   );

   // count above the bitmap size saturates
   assign eff_count      = (slot_count_ff > COUNT_MAX) ? COUNT_MAX : slot_count_ff;
   assign count_words    = eff_count[COUNT_W-1:BIT_SEL_W];
   assign count_bits     = eff_count[BIT_SEL_W-1:0];
   assign count_less_one = eff_count - COUNT_W'(1);
   assign last_word      = count_less_one[SLOT_W-1:BIT_SEL_W];

   assign in_kind  = req_kind_type'(req_tuser);
   assign in_slot  = req_tdata[SLOT_W-1:0];
   assign in_range = {1'b0, in_slot} < eff_count;

   assign scan_word = slot_ff[SLOT_W-1:BIT_SEL_W];

   // slots at or beyond the count never look free
   always_comb begin
      for (int b = 0; b < WORD_W; b++) begin
         scan_mask[b] = ({1'b0, scan_word} < count_words) ||
                        (({1'b0, scan_word} == count_words) && (BIT_SEL_W'(b) < count_bits));
      end
   end

   assign avail = ~rd_data & scan_mask;

   // lowest set bit of the free vector
   always_comb begin
      first_free = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (avail[b]) begin
            first_free = BIT_SEL_W'(b);
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= COUNT_MAX;
      end else if (csr_we) begin
         slot_count_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      slot_ff       <= slot_in;
      beat_ff       <= beat_in;
      status_ff     <= status_in;
      is_write_ff   <= is_write_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_sector_ff <= rsp_sector_in;
      rsp_write_ff  <= rsp_write_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      slot_in       = slot_ff;
      beat_in       = beat_ff;
      status_in     = status_ff;
      is_write_in   = is_write_ff;
      req_tready    = 1'b0;
      map_req       = '0;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_sector_in = rsp_sector_ff;
      rsp_write_in  = rsp_write_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            // no beat is taken while reset is held
            req_tready = !reset;
            if (req_tvalid && req_tready) begin
               kind_in     = in_kind;
               slot_in     = in_slot;
               beat_in     = '0;
               is_write_in = 1'b0;
               case (in_kind)
                  REQ_ALLOC: begin
                     slot_in = '0;
                     if (eff_count == '0) begin
                        status_in = ST_FULL;
                        state_in  = S_RESULT;
                     end else begin
                        map_req.rd_en   = 1'b1;
                        map_req.rd_addr = '0;
                        state_in        = S_SCAN;
                     end
                  end
                  REQ_READ, REQ_FREE: begin
                     if (!in_range) begin
                        status_in = ST_RANGE;
                        state_in  = S_RESULT;
                     end else begin
                        map_req.rd_en   = 1'b1;
                        map_req.rd_addr = in_slot[SLOT_W-1:BIT_SEL_W];
                        state_in        = S_CHECK;
                     end
                  end
                  default: begin
                     // unused request code, dropped without a result
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (avail != '0) begin
               // claim the lowest free slot of this word
               slot_in         = {scan_word, first_free};
               map_req.wr_en   = 1'b1;
               map_req.wr_addr = scan_word;
               map_req.wr_data = rd_data | (WORD_W'(1) << first_free);
               is_write_in     = 1'b1;
               status_in       = ST_OK;
               state_in        = S_EMIT;
            end else if (scan_word == last_word) begin
               slot_in   = '0;
               status_in = ST_FULL;
               state_in  = S_RESULT;
            end else begin
               // read the next word while this one is judged
               slot_in         = {scan_word + MAP_ADDR_W'(1), {BIT_SEL_W{1'b0}}};
               map_req.rd_en   = 1'b1;
               map_req.rd_addr = scan_word + MAP_ADDR_W'(1);
            end
         end

         S_CHECK: begin
            if (!rd_data[slot_ff[BIT_SEL_W-1:0]]) begin
               status_in = ST_NOT_USED;
               state_in  = S_RESULT;
            end else begin
               map_req.wr_en   = 1'b1;
               map_req.wr_addr = scan_word;
               map_req.wr_data = rd_data & ~(WORD_W'(1) << slot_ff[BIT_SEL_W-1:0]);
               status_in       = ST_OK;
               is_write_in     = 1'b0;
               state_in        = (kind_ff == REQ_READ) ? S_EMIT : S_RESULT;
            end
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = slot_ff;
               rsp_sector_in = {slot_ff, beat_ff};
               rsp_write_in  = is_write_ff;
               rsp_status_in = ST_OK;
               rsp_last_in   = (beat_ff == BEAT_LAST);
               beat_in       = beat_ff + BEAT_W'(1);
               if (beat_ff == BEAT_LAST) begin
                  state_in = S_IDLE;
               end
            end
         end

         S_RESULT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = slot_ff;
               rsp_sector_in = '0;
               rsp_write_in  = 1'b0;
               rsp_status_in = status_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_sector_ff, rsp_slot_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_write_ff};
   assign rsp_tlast  = rsp_last_ff;

   // an error result is always the only beat of its request
   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[2:1] != 2'(ST_OK)) |-> rsp_tlast)
      else $error("error result not marked last");

   // transfer beats carry the sector of their own slot
   a_sector_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tdata[22:13] == rsp_tdata[9:0]))
      else $error("sector address does not match slot");

   // an accepted allocate either scans or reports a full table
   a_alloc_path: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == 2'(REQ_ALLOC))
      |=> (state_ff == S_SCAN) || (state_ff == S_RESULT))
      else $error("allocate took an unexpected path");

   // the scan never walks past the last usable word
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (scan_word <= last_word))
      else $error("scan beyond slot count");

endmodule

// File: design/ssba_map.sv
// word-wide used-slot bitmap store with per-word valid flags and registered read
module ssba_map (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ssba_pkg::map_req_type                  map_req,
   output logic [ssba_pkg::WORD_W-1:0]            rd_data
);
   import ssba_pkg::*;

   logic [WORD_W-1:0]    map_mem_ff [MAP_DEPTH];
   logic [MAP_DEPTH-1:0] valid_ff;
   logic [MAP_DEPTH-1:0] valid_in;
   logic [WORD_W-1:0]    rd_word_ff;
   logic                 rd_hit_ff;

   always_comb begin
      valid_in = valid_ff;
      if (map_req.wr_en) begin
         valid_in[map_req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (map_req.wr_en) begin
         map_mem_ff[map_req.wr_addr] <= map_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (map_req.rd_en) begin
         rd_word_ff <= map_mem_ff[map_req.rd_addr];
         rd_hit_ff  <= valid_ff[map_req.rd_addr];
      end
   end

   // a word never written since reset reads as all free
   assign rd_data = rd_hit_ff ? rd_word_ff : '0;

endmodule

// File: tb/swap_slot_bitmap_allocator_test.sv
// self-checking testbench for the swap slot bitmap allocator: directed table, then random phases
module swap_slot_bitmap_allocator_test;
   import ssba_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 6;
   // quiet margin after the last expected beat before a register write
   localparam int DRAIN_CYCLES = 64;
   localparam int HOLD_CYCLES  = 300;
   // no beat on either side for this long means the block is stuck
   localparam int QUIET_LIMIT  = 4000;

   // one result beat, same fields as the rsp channel carries
   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      logic [SECTOR_W-1:0] sector;
      logic                wr;
      status_type          status;
      logic                last;
   } transfer_beat_type;

   typedef enum logic {
      ROW_REQ,
      ROW_CSR
   } row_op_type;

   // directed row: a request or a slot count write; known rows carry their single
   // beat typed in (slot_number = arg, no transfer, last set)
   typedef struct {
      row_op_type   op;
      req_kind_type kind;
      int unsigned  arg;
      logic         known;
      status_type   k_status;
   } plan_row_type;

   typedef struct {
      int unsigned count;
      int          items;
      int          alloc_pct;
      bit          calm;
      bit          hold;
      bit          pause;
   } phase_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata  = '0;   // [9:0] slot_index, rest zero
   logic [1:0]          req_tuser  = '0;   // [1:0] req_type
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [23:0]         rsp_tdata;         // [9:0] slot_number, [22:10] sector_address
   logic [2:0]          rsp_tuser;         // [0] is_write, [2:1] status
   logic                rsp_tlast;
   logic                csr_we     = 1'b0;
   logic [COUNT_W-1:0]  csr_wdata  = '0;   // slot_count

   // shadow of the block: used bit per slot and the slot count register
   logic                used_bits [MAX_SLOTS];
   logic [COUNT_W-1:0]  slot_count_shadow;
   transfer_beat_type   expected_beats [$];

   int   mismatches  = 0;
   logic calm        = 1'b0;   // no idling on either side while set
   int   hold_ticket = 0;      // bumped by the stimulus to ask for a long rsp hold-off
   int   hold_served = 0;
   int   hold_left   = 0;

   always #HALF_PERIOD clock = ~clock;

   swap_slot_bitmap_allocator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // counts above the table size saturate
   function automatic int usable_slots();
      return (slot_count_shadow > COUNT_MAX) ? MAX_SLOTS : int'(slot_count_shadow);
   endfunction

   function automatic void push_single(logic [SLOT_W-1:0] slot, status_type status);
      expected_beats.push_back('{slot, '0, 1'b0, status, 1'b1});
   endfunction

   // eight sector beats for one slot, last one marked
   function automatic void push_sectors(logic [SLOT_W-1:0] slot, logic wr);
      transfer_beat_type b;
      int i;
      for (i = 0; i < SECTORS_PER_SLOT; i++) begin
         b.slot   = slot;
         b.sector = SECTOR_W'(int'(slot) * SECTORS_PER_SLOT + i);
         b.wr     = wr;
         b.status = ST_OK;
         b.last   = (i == SECTORS_PER_SLOT - 1);
         expected_beats.push_back(b);
      end
   endfunction

   // apply one accepted request to the shadow and queue its beats; returns the beat count
   function automatic int predict_transfers(req_kind_type kind, logic [SLOT_W-1:0] idx);
      int lim;
      int s;
      int found;
      lim   = usable_slots();
      found = -1;
      case (kind)
         REQ_ALLOC: begin
            // first fit from slot zero
            for (s = 0; s < lim && found < 0; s++) begin
               if (!used_bits[s]) found = s;
            end
            if (found < 0) begin
               push_single('0, ST_FULL);
               return 1;
            end
            used_bits[found] = 1'b1;
            push_sectors(SLOT_W'(found), 1'b1);
            return SECTORS_PER_SLOT;
         end
         REQ_NONE: begin
            return 0;
         end
         default: begin
            if (int'(idx) >= lim) begin
               push_single(idx, ST_RANGE);
               return 1;
            end
            if (!used_bits[idx]) begin
               push_single(idx, ST_NOT_USED);
               return 1;
            end
            used_bits[idx] = 1'b0;
            if (kind == REQ_READ) begin
               push_sectors(idx, 1'b0);
               return SECTORS_PER_SLOT;
            end
            push_single(idx, ST_OK);
            return 1;
         end
      endcase
   endfunction

   // mostly slots in use so read back and free get past the checks, then range edges, then noise
   function automatic logic [SLOT_W-1:0] choose_slot();
      int unsigned live [$];
      int lim;
      int roll;
      int s;
      lim  = usable_slots();
      roll = $urandom_range(99);
      if (roll < 65) begin
         for (s = 0; s < MAX_SLOTS; s++) begin
            if (used_bits[s]) live.push_back(s);
         end
         if (live.size() > 0) return SLOT_W'(live[$urandom_range(live.size() - 1)]);
      end
      if (roll < 80) return SLOT_W'((lim == 0) ? 0 : lim - 1 + $urandom_range(1));
      return SLOT_W'($urandom_range(MAX_SLOTS - 1));
   endfunction

   function automatic req_kind_type choose_kind(int alloc_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < 4) return REQ_NONE;
      if (roll < 4 + alloc_pct) return REQ_ALLOC;
      return $urandom_range(1) ? REQ_READ : REQ_FREE;
   endfunction

   // random idle cycles first, then hold the beat until the block takes it
   task automatic offer_request(input req_kind_type kind, input logic [SLOT_W-1:0] idx,
                                output int pushed);
      while (!calm && $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= 16'(idx);
      do begin
         @(posedge clock);
      end while (!req_tready);
      pushed = predict_transfers(kind, idx);
   endtask

   // stop offering until every expected beat is back and the block has gone quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_slot_count(input logic [COUNT_W-1:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we            <= 1'b0;
      slot_count_shadow = value;
   endtask

   // rsp side: random stalls, or a long hold-off when the stimulus asks for one
   always @(posedge clock) begin : receiver
      if (hold_served != hold_ticket) begin
         hold_served = hold_ticket;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 9);
      end
   end

   // every accepted rsp beat against the oldest expectation
   // fields printed as slot:sector:write:status:last
   always @(posedge clock) begin : result_monitor
      transfer_beat_type got;
      transfer_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[SLOT_W-1:0], rsp_tdata[SLOT_W+SECTOR_W-1:SLOT_W], rsp_tuser[0],
                 status_type'(rsp_tuser[2:1]), rsp_tlast};
         if (expected_beats.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected beat, expected none, got %0d:%0d:%0b:%0d:%0b",
                     $time, got.slot, got.sector, got.wr, got.status, got.last);
         end else begin
            want = expected_beats.pop_front();
            if (got !== want) begin
               mismatches++;
               $display("%0t: expected %0d:%0d:%0b:%0d:%0b got %0d:%0d:%0b:%0d:%0b",
                        $time, want.slot, want.sector, want.wr, want.status, want.last,
                        got.slot, got.sector, got.wr, got.status, got.last);
            end
         end
      end
   end

   // ends the run when neither channel moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("[swap_slot_bitmap_allocator] ERROR");
      $finish;
   end

   initial begin : stimulus
      plan_row_type      plan [$];
      phase_type         phases [$];
      req_kind_type      kind;
      int                pushed;
      int                sent;

      used_bits         = '{default: 1'b0};
      slot_count_shadow = COUNT_MAX;

      plan = '{
         // fresh table: nothing in use yet
         '{ROW_REQ, REQ_READ,  0,    1'b1, ST_NOT_USED},
         '{ROW_REQ, REQ_FREE,  1023, 1'b1, ST_NOT_USED},
         '{ROW_REQ, REQ_ALLOC, 0,    1'b0, ST_OK},        // slot 0
         '{ROW_REQ, REQ_ALLOC, 1023, 1'b0, ST_OK},        // slot 1, index ignored
         '{ROW_REQ, REQ_NONE,  1023, 1'b0, ST_OK},        // reserved type, no beat
         '{ROW_REQ, REQ_READ,  0,    1'b0, ST_OK},        // eight reads, slot 0 freed
         '{ROW_REQ, REQ_FREE,  1,    1'b1, ST_OK},
         '{ROW_REQ, REQ_FREE,  1,    1'b1, ST_NOT_USED},  // double free
         '{ROW_REQ, REQ_ALLOC, 0,    1'b0, ST_OK},        // slot 0 again
         // zero slots usable
         '{ROW_CSR, REQ_NONE,  0,    1'b0, ST_OK},
         '{ROW_REQ, REQ_ALLOC, 0,    1'b1, ST_FULL},
         '{ROW_REQ, REQ_READ,  0,    1'b1, ST_RANGE},
         '{ROW_REQ, REQ_FREE,  1023, 1'b1, ST_RANGE},
         // one slot, already taken
         '{ROW_CSR, REQ_NONE,  1,    1'b0, ST_OK},
         '{ROW_REQ, REQ_ALLOC, 0,    1'b1, ST_FULL},
         '{ROW_REQ, REQ_READ,  1,    1'b1, ST_RANGE},
         '{ROW_REQ, REQ_FREE,  0,    1'b1, ST_OK},
         '{ROW_REQ, REQ_ALLOC, 0,    1'b0, ST_OK},        // slot 0
         // count beyond the table saturates
         '{ROW_CSR, REQ_NONE,  2047, 1'b0, ST_OK},
         '{ROW_REQ, REQ_ALLOC, 0,    1'b0, ST_OK},        // slot 1
         '{ROW_REQ, REQ_READ,  1023, 1'b1, ST_NOT_USED},
         '{ROW_REQ, REQ_NONE,  0,    1'b0, ST_OK},
         '{ROW_REQ, REQ_READ,  1,    1'b0, ST_OK},        // eight reads, slot 1 freed
         '{ROW_CSR, REQ_NONE,  1024, 1'b0, ST_OK}
      };

      // count, items, allocate share, no idling, rsp hold-off, mid-phase drain
      phases = '{
         '{1024, 70, 45, 1'b0, 1'b1, 1'b0},
         '{8,    40, 50, 1'b0, 1'b0, 1'b0},
         '{1,    20, 40, 1'b0, 1'b0, 1'b0},
         '{2047, 40, 45, 1'b0, 1'b0, 1'b0},
         '{1024, 60, 80, 1'b1, 1'b0, 1'b0},   // allocate-heavy, pushes the scan over more words
         '{33,   40, 45, 1'b0, 1'b0, 1'b1},
         '{0,    15, 30, 1'b0, 1'b0, 1'b0},
         '{1023, 40, 45, 1'b0, 1'b0, 1'b0}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         if (plan[r].op == ROW_CSR) begin
            write_slot_count(COUNT_W'(plan[r].arg));
         end else begin
            offer_request(plan[r].kind, SLOT_W'(plan[r].arg), pushed);
            // typed rows replace what the shadow queued; its state update stays
            if (plan[r].known) begin
               repeat (pushed) void'(expected_beats.pop_back());
               push_single(SLOT_W'(plan[r].arg), plan[r].k_status);
            end
         end
      end

      foreach (phases[p]) begin
         write_slot_count(COUNT_W'(phases[p].count));
         calm = phases[p].calm;
         // receiver stops while the sender keeps offering, so the block backs up
         if (phases[p].hold) hold_ticket++;
         sent = 0;
         while (sent < phases[p].items) begin
            kind = choose_kind(phases[p].alloc_pct);
            offer_request(kind, choose_slot(), pushed);
            if (kind != REQ_NONE) begin
               sent++;
               // sender waits until every outstanding beat is back
               if (phases[p].pause && sent == phases[p].items / 2) settle();
            end
         end
         calm = 1'b0;
      end

      settle();
      if (mismatches == 0) begin
         $display("[swap_slot_bitmap_allocator] OK");
      end else begin
         $display("[swap_slot_bitmap_allocator] ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
design/ssba_pkg.sv
design/ssba_map.sv
design/swap_slot_bitmap_allocator.sv
tb/swap_slot_bitmap_allocator_test.sv
